FILE: hw/rtl/tlpe_pkg.sv
// ----------------------------------------------------------------------------
// tlpe_pkg: shared types and constants of the tagged line payload extractor
// Line geometry, tag bytes, request codes and the command word that the
// front part hands to the back part through the command queue.
// ----------------------------------------------------------------------------
package tlpe_pkg;

  localparam int LINE_BYTES = 256;
  localparam int LINE_W     = $clog2(LINE_BYTES);
  localparam int ADDR_W     = LINE_W + 1;
  localparam int MEM_DEPTH  = 2 * LINE_BYTES;
  localparam int CMP_W      = LINE_W + 1;

  localparam int TAG_COUNT = 15;
  localparam int TAG_IW    = $clog2(TAG_COUNT);

  localparam logic [7:0] TAG_BYTES [TAG_COUNT] = '{
    8'h5B, 8'h42, 8'h4F, 8'h54, 8'h5F, 8'h52, 8'h45, 8'h53,
    8'h50, 8'h4F, 8'h4E, 8'h53, 8'h45, 8'h3A, 8'h20
  };

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CLOSE = 8'h5D;
  localparam logic [7:0] CH_ZERO  = 8'h00;

  localparam logic [1:0] REQ_BYTE  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_CLAIM = 2'd2;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
    logic              resp_ready;
    logic [7:0]        resp_length;
    logic              latched_now;
  } cmd_t;

endpackage

FILE: hw/rtl/tlpe_front.sv
// ----------------------------------------------------------------------------
// tlpe_front: request intake and line tracking
// Accepts requests, follows the line being assembled, keeps the latched
// response state and turns every request into one command for the back part.
// ----------------------------------------------------------------------------
module tlpe_front
  import tlpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [1:0]            s_tuser,
  input  logic                  q_full,
  output logic                  push,
  output cmd_t                  cmd
);

  localparam logic [LINE_W-1:0] TAG_LEN  = LINE_W'(TAG_COUNT);
  localparam logic [LINE_W-1:0] LINE_MAX = LINE_W'(LINE_BYTES - 1);

  logic [LINE_W-1:0] line_count, line_count_next;
  logic              prefix_ok, prefix_ok_next;
  logic              zero_seen, zero_seen_next;
  logic [LINE_W-1:0] last_close_pos, last_close_pos_next;
  logic              active_bank, active_bank_next;
  logic [LINE_W-1:0] latched_len, latched_len_next;
  logic              latched_valid, latched_valid_next;

  logic [1:0]        req_type;
  logic [7:0]        rx_data;
  logic [7:0]        read_index;
  logic [8:0]        read_limit;
  logic [8:0]        limit_m1;
  logic [CMP_W-1:0]  len_ext;
  logic [CMP_W-1:0]  lim_ext;
  logic [LINE_W-1:0] index_ext;

  assign req_type   = s_tuser;
  assign rx_data    = s_tdata[7:0];
  assign read_index = s_tdata[15:8];
  assign read_limit = s_tdata[24:16];

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  assign limit_m1  = read_limit - 9'd1;
  assign len_ext   = CMP_W'(latched_len);
  assign lim_ext   = CMP_W'(limit_m1);
  assign index_ext = LINE_W'(read_index);

  always_comb begin
    line_count_next     = line_count;
    prefix_ok_next      = prefix_ok;
    zero_seen_next      = zero_seen;
    last_close_pos_next = last_close_pos;
    active_bank_next    = active_bank;
    latched_len_next    = latched_len;
    latched_valid_next  = latched_valid;
    cmd                 = '0;
    cmd.wdata           = rx_data;

    if (push) begin
      unique case (req_type)
        REQ_BYTE: begin
          if (rx_data == CH_NL) begin
            if (prefix_ok && line_count >= TAG_LEN && last_close_pos > TAG_LEN) begin
              active_bank_next   = !active_bank;
              latched_len_next   = last_close_pos - TAG_LEN;
              latched_valid_next = 1'b1;
              cmd.latched_now    = 1'b1;
            end
            line_count_next     = '0;
            prefix_ok_next      = 1'b1;
            zero_seen_next      = 1'b0;
            last_close_pos_next = '0;
          end else if (line_count < LINE_MAX) begin
            if (line_count < TAG_LEN) begin
              if (zero_seen || rx_data != TAG_BYTES[line_count[TAG_IW-1:0]]) begin
                prefix_ok_next = 1'b0;
              end
            end else begin
              // Payload bytes go to the bank that is not being read.
              cmd.wr_en = 1'b1;
              cmd.addr  = {!active_bank, line_count - TAG_LEN};
              if (!zero_seen && rx_data == CH_CLOSE) begin
                last_close_pos_next = line_count;
              end
            end
            if (rx_data == CH_ZERO) begin
              zero_seen_next = 1'b1;
            end
            line_count_next = line_count + LINE_W'(1);
          end else begin
            line_count_next     = '0;
            prefix_ok_next      = 1'b1;
            zero_seen_next      = 1'b0;
            last_close_pos_next = '0;
          end
        end
        REQ_READ: begin
          cmd.rd_en = (index_ext < latched_len);
          cmd.addr  = {active_bank, index_ext};
        end
        REQ_CLAIM: begin
          if (latched_valid && read_limit != 9'd0) begin
            cmd.resp_ready     = 1'b1;
            cmd.resp_length    = (len_ext > lim_ext) ? 8'(lim_ext) : 8'(len_ext);
            latched_valid_next = 1'b0;
          end
        end
        default: begin
          cmd = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= '0;
      prefix_ok      <= 1'b1;
      zero_seen      <= 1'b0;
      last_close_pos <= '0;
      active_bank    <= 1'b0;
      latched_len    <= '0;
      latched_valid  <= 1'b0;
    end else begin
      line_count     <= line_count_next;
      prefix_ok      <= prefix_ok_next;
      zero_seen      <= zero_seen_next;
      last_close_pos <= last_close_pos_next;
      active_bank    <= active_bank_next;
      latched_len    <= latched_len_next;
      latched_valid  <= latched_valid_next;
    end
  end

endmodule

FILE: hw/rtl/tlpe_cmd_queue.sv
// ----------------------------------------------------------------------------
// tlpe_cmd_queue: command queue between front and back
// A small first-in first-out buffer that lets intake and delivery stall
// independently of each other.
// ----------------------------------------------------------------------------
module tlpe_cmd_queue
  import tlpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full       = (count == (QPTR_W + 1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W + 1)'(1);
      end
    end
  end

endmodule

FILE: hw/rtl/tlpe_back.sv
// ----------------------------------------------------------------------------
// tlpe_back: payload store and result register
// Carries out queued commands against the two-bank payload store and holds
// each result in an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module tlpe_back
  import tlpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  head_valid,
  input  cmd_t                  head,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic [7:0] mem [MEM_DEPTH];
  logic [7:0] mem_q;
  logic       out_valid;
  logic       rd_en_q;
  logic       resp_ready_q;
  logic [7:0] resp_length_q;
  logic       latched_now_q;
  logic [7:0] read_byte;

  assign pop = head_valid && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (pop && head.wr_en) begin
      mem[head.addr] <= head.wdata;
    end
    if (pop && head.rd_en) begin
      mem_q <= mem[head.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_en_q       <= head.rd_en;
      resp_ready_q  <= head.resp_ready;
      resp_length_q <= head.resp_length;
      latched_now_q <= head.latched_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  assign read_byte = rd_en_q ? mem_q : 8'd0;
  assign m_tvalid  = out_valid;
  assign m_tdata   = {6'd0, latched_now_q, resp_length_q, resp_ready_q, read_byte};

endmodule

FILE: hw/rtl/tagged_line_payload_extractor_core.sv
// ----------------------------------------------------------------------------
// tagged_line_payload_extractor_core: tagged line payload extractor
// Builds text lines from received bytes, latches the payload of tagged lines
// and answers payload read and response claim requests.
// ----------------------------------------------------------------------------
// Use: requests arrive on the s_ stream channel, one request per transfer;
// s_tuser carries the request kind (received byte, payload read or claim)
// and s_tdata its operands. Every request yields exactly one result transfer
// on the m_ channel, in request order.
// A request passes through a command queue entry, then the store read into
// the output register. Throughput is one request per cycle while the
// receiver keeps m_tready high; the single-port payload store does one
// access per command, which sets that rate.
// Reset clears the line tracker and any pending response; the payload store
// is not cleared, and only entries written since reset are ever read.
// When the receiver stalls, the output register and a four-entry command
// queue absorb requests; s_tready falls only once that queue is full.
// ----------------------------------------------------------------------------
module tagged_line_payload_extractor_core
  import tlpe_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // rx_data[7:0], read_index[15:8], read_limit[24:16]
  input  logic [1:0]            s_tuser,   // req_type[1:0]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // read_byte[7:0], resp_ready[8],
                                           // resp_length[16:9], latched_now[17]
);

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head;

  tlpe_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .cmd      (push_cmd)
  );

  tlpe_cmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tlpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // A claim and a latch come from different request kinds.
  a_one_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[8] && m_tdata[17]))
    else $error("result flags both a claim and a latch");

  // A claim that found nothing reports zero length.
  a_len_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[8]) |-> (m_tdata[16:9] == 8'd0))
    else $error("nonzero length without a ready response");

  // A nonzero payload byte only comes from a read request.
  a_read_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[7:0] != 8'd0) |-> (!m_tdata[8] && !m_tdata[17]))
    else $error("payload byte mixed with claim or latch result");

  // A queued command never waits while the output register is free.
  a_no_bubble: assert property (@(posedge clk) disable iff (rst)
    (head_valid && !m_tvalid) |-> pop)
    else $error("back part idles with work queued");
`endif

endmodule
